// ----- hw/rtl/drt_pkg.sv -----
// Shared types and constants for the dense ranking block.
`timescale 1ns / 1ps
package drt_pkg;

    localparam int SLOT_W      = 6;
    localparam int CNT_W       = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QFILL_W     = 3;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] score;
        logic               present;
        logic               store;
        logic [SLOT_W-1:0]  slot;
        logic               last;
        logic [CNT_W-1:0]   count;
    } drt_entry_t;

endpackage

// ----- hw/rtl/drt_queue.sv -----
// Short queue between the loading front end and the ranking back end.
`timescale 1ns / 1ps
module drt_queue
    import drt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  drt_entry_t wr_data,
    output logic       rd_valid,
    input  logic       rd_ready,
    output drt_entry_t rd_data
);

    drt_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;
    logic              push;
    logic              pop;

    assign wr_ready = (fill_reg != QFILL_W'(QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/drt_front.sv -----
// Input side: accepts words, assigns slots and marks the end of each run.
`timescale 1ns / 1ps
module drt_front
    import drt_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        q_valid,
    input  logic        q_ready,
    output drt_entry_t  q_data
);

    logic [CNT_W-1:0] load_cnt_reg;
    logic [CNT_W-1:0] load_cnt_next;
    logic             store;
    logic             accept;

    assign s_axis_tready = q_ready;
    assign q_valid       = s_axis_tvalid;
    assign accept        = s_axis_tvalid && q_ready;
    assign store         = (load_cnt_reg < CNT_W'(NUM_SLOTS));

    always_comb begin
        q_data.key     = s_axis_tdata[31:0];
        q_data.score   = s_axis_tdata[63:32];
        q_data.present = s_axis_tdata[64];
        q_data.store   = store;
        q_data.slot    = load_cnt_reg[SLOT_W-1:0];
        q_data.last    = s_axis_tlast;
        q_data.count   = store ? load_cnt_reg + 1'b1 : load_cnt_reg;
        if (s_axis_tlast) begin
            load_cnt_next = '0;
        end else if (store) begin
            load_cnt_next = load_cnt_reg + 1'b1;
        end else begin
            load_cnt_next = load_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg <= '0;
        end else if (accept) begin
            load_cnt_reg <= load_cnt_next;
        end
    end

endmodule

// ----- hw/rtl/drt_back.sv -----
// Ranking side: stores entries, runs the pairwise ranking pass and emits results.
`timescale 1ns / 1ps
module drt_back
    import drt_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  drt_entry_t  q_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DUP  = 3'd1;
    localparam logic [2:0] ST_RANK = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [IDX_W-1:0]     j_reg;
    logic [IDX_W-1:0]     j_next;
    logic [IDX_W-1:0]     k_reg;
    logic [IDX_W-1:0]     k_next;
    logic [IDX_W-1:0]     s_reg;
    logic [IDX_W-1:0]     s_next;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [NUM_SLOTS-1:0] present_reg;
    logic [NUM_SLOTS-1:0] dup_reg;
    logic                 stg_valid_reg;
    logic                 stg_dup_reg;
    logic [IDX_W-1:0]     stg_a_reg;
    logic [IDX_W-1:0]     stg_b_reg;
    logic [63:0]          mem [NUM_SLOTS];
    logic [63:0]          rd_a_reg;
    logic [63:0]          rd_b_reg;
    logic [IDX_W-1:0]     addr_a;
    logic [IDX_W-1:0]     addr_b;
    logic                 issue;
    logic [IDX_W-1:0]     last_idx;
    logic                 pop;
    logic                 wr_en;
    logic                 out_free;
    logic                 out_load;
    logic                 run_done;
    logic signed [31:0]   key_a;
    logic signed [31:0]   key_b;
    logic signed [31:0]   score_a;
    logic signed [31:0]   score_b;
    logic                 same_pair;
    logic                 a_beats_b;
    logic                 m_tvalid_reg;
    logic [15:0]          m_tdata_reg;
    logic                 m_tlast_reg;
    logic [CNT_W-1:0]     place;

    assign q_ready  = (state_reg == ST_IDLE);
    assign pop      = q_valid && q_ready;
    assign wr_en    = pop && q_data.store;
    assign last_idx = IDX_W'(n_reg - 1'b1);
    assign out_free = !m_tvalid_reg || m_axis_tready;
    assign out_load = (state_reg == ST_EMIT) && out_free;
    assign run_done = out_load && (s_reg == last_idx);

    assign key_a     = rd_a_reg[31:0];
    assign score_a   = rd_a_reg[63:32];
    assign key_b     = rd_b_reg[31:0];
    assign score_b   = rd_b_reg[63:32];
    assign same_pair = (key_a == key_b) && (score_a == score_b);
    assign a_beats_b = (key_a < key_b) || ((key_a == key_b) && (score_a > score_b));

    assign place = present_reg[s_reg] ? cnt_reg + 1'b1 : '0;

    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        s_next     = s_reg;
        issue      = 1'b0;
        addr_a     = j_reg;
        addr_b     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop && q_data.last) begin
                    s_next = '0;
                    k_next = '0;
                    if (q_data.count > CNT_W'(1)) begin
                        j_next     = IDX_W'(1);
                        state_next = ST_DUP;
                    end else begin
                        j_next     = '0;
                        state_next = ST_RANK;
                    end
                end
            end
            ST_DUP: begin
                issue = 1'b1;
                if (k_reg == j_reg - 1'b1) begin
                    k_next = '0;
                    if (j_reg == last_idx) begin
                        j_next     = '0;
                        state_next = ST_RANK;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_RANK: begin
                issue  = 1'b1;
                addr_b = s_reg;
                if (j_reg == last_idx) begin
                    state_next = ST_WAIT;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    j_next = '0;
                    if (s_reg == last_idx) begin
                        state_next = ST_IDLE;
                    end else begin
                        s_next     = s_reg + 1'b1;
                        state_next = ST_RANK;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[q_data.slot[IDX_W-1:0]] <= {q_data.score, q_data.key};
        end
        rd_a_reg  <= mem[addr_a];
        rd_b_reg  <= mem[addr_b];
        stg_dup_reg <= (state_reg == ST_DUP);
        stg_a_reg <= addr_a;
        stg_b_reg <= addr_b;
        if (pop && q_data.last) begin
            n_reg <= q_data.count;
        end
        if (out_load) begin
            m_tdata_reg <= {2'b00, present_reg[s_reg], place, SLOT_W'(s_reg)};
            m_tlast_reg <= (s_reg == last_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            j_reg         <= '0;
            k_reg         <= '0;
            s_reg         <= '0;
            cnt_reg       <= '0;
            present_reg   <= '0;
            dup_reg       <= '0;
            stg_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            s_reg         <= s_next;
            stg_valid_reg <= issue;
            if (wr_en) begin
                present_reg[q_data.slot[IDX_W-1:0]] <= q_data.present;
            end
            if (stg_valid_reg && stg_dup_reg) begin
                if (present_reg[stg_a_reg] && present_reg[stg_b_reg] && same_pair) begin
                    dup_reg[stg_a_reg] <= 1'b1;
                end
            end
            if (out_load) begin
                cnt_reg <= '0;
            end else if (stg_valid_reg && !stg_dup_reg) begin
                if (present_reg[stg_a_reg] && !dup_reg[stg_a_reg] && a_beats_b) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (run_done) begin
                present_reg <= '0;
                dup_reg     <= '0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tlast  = m_tlast_reg;

endmodule

// ----- hw/rtl/dense_rank_with_tiebreak.sv -----
// Top level of the dense ranking block: front end, queue and ranking back end.
// Words load via a four-word queue into slot memory, one per cycle while it is not full.
// After the word with tlast, a pass over n loaded slots compares every pair to mark
// duplicates, then ranks each slot against all n slots via the two-port slot memory.
// Each result word leaves from an output register; new words queue during the pass.
// Reset (synchronous, aresetn low) clears counters, presence and state; slot data is kept.
`timescale 1ns / 1ps
module dense_rank_with_tiebreak
    import drt_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: primary_key[31:0], tie_score[63:32], present[64], zero pad.
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: slot_index[5:0], place[12:6], assigned[13], zero pad.
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    drt_entry_t fq_data;
    logic       fq_valid;
    logic       fq_ready;
    drt_entry_t qb_data;
    logic       qb_valid;
    logic       qb_ready;

    drt_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    drt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    drt_back #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_data        (qb_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
